// ===== rtl/dtc_pkg.sv =====
package dtc_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned TypeW = 2;
    localparam int unsigned MantW = 24;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned CntW  = 6;

    localparam logic [WordW-1:0] AllOnes  = {WordW{1'b1}};
    localparam logic [ExpW-1:0]  ExpMin   = 8'd3;
    localparam logic [ExpW-1:0]  ExpMax   = 8'd10;

    typedef enum logic [TypeW-1:0] {
        REQ_TGT_TO_DIFF  = 2'd0,
        REQ_DIFF_TO_TGT  = 2'd1,
        REQ_CMPCT_TO_TGT = 2'd2,
        REQ_UNUSED       = 2'd3
    } t_req_type;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/dtc_if.sv =====
interface dtc_req_if
    import dtc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TypeW-1:0]   req_type;
    logic [WordW-1:0]   operand;

    modport source (output valid, output req_type, output operand, input ready);
    modport sink   (input valid, input req_type, input operand, output ready);
endinterface

interface dtc_rsp_if
    import dtc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WordW-1:0]   result_value;
    logic               bad_exponent;

    modport source (output valid, output result_value, output bad_exponent, input ready);
    modport sink   (input valid, input result_value, input bad_exponent, output ready);
endinterface

// ===== rtl/difficulty_target_converter.sv =====
// Channel  | Dir | Payload                          | Transaction
// i_req    | in  | req_type[1:0], operand[63:0]     | valid && ready
// o_rsp    | out | result_value[63:0], bad_exponent | valid && ready
//
// A request that needs a division launches the shared radix-2 divider, which runs 64
// one-bit steps and raises its done flag; the quotient is then registered and o_rsp.valid
// goes high. Requests that need no division (zero target, zero difficulty, bad exponent,
// zero scaled mantissa, unused type) go from idle straight to the state that raises o_rsp.valid.
// One request is in flight at a time; i_req.ready is low until the response transaction
// completes. Reset is synchronous, active low, and returns the block to idle.
module difficulty_target_converter
    import dtc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    dtc_req_if.sink  i_req,
    dtc_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [WordW-1:0] r_res;
    logic             r_bad;
    t_div_ctrl        r_ctrl;
    logic [WordW-1:0] r_dvs;

    t_div_stat        w_stat;
    logic [WordW-1:0] w_quo;

    logic [MantW-1:0] w_mant;
    logic [ExpW-1:0]  w_exp;
    logic [2:0]       w_k;
    logic [WordW-1:0] w_scaled;
    logic             w_exp_bad;

    assign w_mant    = i_req.operand[MantW-1:0];
    assign w_exp     = i_req.operand[MantW+ExpW-1:MantW];
    assign w_k       = 3'(w_exp - ExpMin);
    assign w_exp_bad = (w_exp < ExpMin) || (w_exp > ExpMax);
    assign w_scaled  = {{(WordW-MantW){1'b0}}, w_mant} << {w_k, 3'b000};

    dtc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (r_ctrl),
        .i_divisor  (r_dvs),
        .o_stat     (w_stat),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ctrl.start <= 1'b0;
        end else begin
            r_ctrl.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_bad <= 1'b0;
                        case (t_req_type'(i_req.req_type))
                            REQ_TGT_TO_DIFF: begin
                                if (i_req.operand == '0) begin
                                    r_res   <= {{(WordW-1){1'b0}}, 1'b1};
                                    r_state <= S_OUT;
                                end else begin
                                    r_dvs        <= i_req.operand;
                                    r_ctrl.start <= 1'b1;
                                    r_state      <= S_DIV;
                                end
                            end
                            REQ_DIFF_TO_TGT: begin
                                // A zero difficulty counts as one.
                                if (i_req.operand == '0) begin
                                    r_res   <= AllOnes;
                                    r_state <= S_OUT;
                                end else begin
                                    r_dvs        <= i_req.operand;
                                    r_ctrl.start <= 1'b1;
                                    r_state      <= S_DIV;
                                end
                            end
                            REQ_CMPCT_TO_TGT: begin
                                if (w_exp_bad) begin
                                    r_bad   <= 1'b1;
                                    r_res   <= '0;
                                    r_state <= S_OUT;
                                end else if (w_scaled == '0) begin
                                    r_res   <= AllOnes;
                                    r_state <= S_OUT;
                                end else begin
                                    r_dvs        <= w_scaled;
                                    r_ctrl.start <= 1'b1;
                                    r_state      <= S_DIV;
                                end
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_stat.done) begin
                        r_res   <= w_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = (r_state == S_OUT);
    assign o_rsp.result_value = r_res;
    assign o_rsp.bad_exponent = r_bad;

endmodule

// ===== rtl/dtc_div.sv =====
module dtc_div
    import dtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctrl        i_ctrl,
    input  logic [WordW-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [WordW-1:0] o_quotient
);

    // Restoring radix-2 division of the all-ones word by a nonzero divisor.
    // One quotient bit per cycle; the dividend bits are all ones, so a one
    // is shifted into the partial remainder on every step.
    logic [WordW-1:0] r_rem, n_rem;
    logic [WordW-1:0] r_quo, n_quo;
    logic [WordW-1:0] r_dvs;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WordW:0]   w_trial;
    logic [WordW:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, 1'b1};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (!w_diff[WordW]) begin
            n_rem = w_diff[WordW-1:0];
            n_quo = {r_quo[WordW-2:0], 1'b1};
        end else begin
            n_rem = w_trial[WordW-1:0];
            n_quo = {r_quo[WordW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_rem  <= '0;
                r_quo  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== verif/tb_difficulty_target_converter.sv =====
module tb_difficulty_target_converter
    import dtc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumDirected  = 24;
    localparam int NumRandom    = 1200;
    localparam int DrainCycles  = 80;
    localparam int LongHoldOff  = 400;

    typedef struct packed {
        logic [WordW-1:0] value;
        logic             bad;
    } t_conversion;

    typedef struct {
        t_req_type        kind;
        logic [WordW-1:0] operand;
        bit               typed;
        t_conversion      want;
    } t_vector;

    logic i_clk;
    logic i_rst_n;
    logic burst_mode;
    int   mismatches;
    int   rsp_count;

    t_conversion pending_results[$];

    dtc_req_if req_if ();
    dtc_rsp_if rsp_if ();

    difficulty_target_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Rows with a typed result can be read straight off the conversion rules;
    // the others go through the predictor.
    t_vector directed_vectors [NumDirected] = '{
        '{REQ_TGT_TO_DIFF,  64'h0000_0000_0000_0000, 1'b1, '{64'd1, 1'b0}},
        '{REQ_TGT_TO_DIFF,  64'h0000_0000_0000_0001, 1'b1, '{AllOnes, 1'b0}},
        '{REQ_TGT_TO_DIFF,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{64'd1, 1'b0}},
        '{REQ_TGT_TO_DIFF,  64'h8000_0000_0000_0000, 1'b1, '{64'd1, 1'b0}},
        '{REQ_TGT_TO_DIFF,  64'h0000_0000_0000_0002, 1'b1,
          '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0}},
        '{REQ_TGT_TO_DIFF,  64'h0123_4567_89AB_CDEF, 1'b0, '{64'd0, 1'b0}},
        '{REQ_DIFF_TO_TGT,  64'h0000_0000_0000_0000, 1'b1, '{AllOnes, 1'b0}},
        '{REQ_DIFF_TO_TGT,  64'h0000_0000_0000_0001, 1'b1, '{AllOnes, 1'b0}},
        '{REQ_DIFF_TO_TGT,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{64'd1, 1'b0}},
        '{REQ_DIFF_TO_TGT,  64'h0000_0000_0000_0003, 1'b1,
          '{64'h5555_5555_5555_5555, 1'b0}},
        '{REQ_DIFF_TO_TGT,  64'hFFFF_FFFF_0000_0000, 1'b0, '{64'd0, 1'b0}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_02FF_FFFF, 1'b1, '{64'd0, 1'b1}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0B00_0001, 1'b1, '{64'd0, 1'b1}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0012_3456, 1'b1, '{64'd0, 1'b1}},
        '{REQ_CMPCT_TO_TGT, 64'hFFFF_FFFF_FF00_0001, 1'b1, '{64'd0, 1'b1}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0300_0000, 1'b1, '{AllOnes, 1'b0}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0300_0001, 1'b1, '{AllOnes, 1'b0}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0A00_0001, 1'b1,
          '{64'h0000_0000_0000_00FF, 1'b0}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0A00_0100, 1'b1, '{AllOnes, 1'b0}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0AFF_FFFF, 1'b0, '{64'd0, 1'b0}},
        '{REQ_CMPCT_TO_TGT, 64'hFFFF_FFFF_0400_1234, 1'b0, '{64'd0, 1'b0}},
        '{REQ_CMPCT_TO_TGT, 64'h0000_0000_0700_ABCD, 1'b0, '{64'd0, 1'b0}},
        '{REQ_UNUSED,       64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{64'd0, 1'b0}},
        '{REQ_UNUSED,       64'h0000_0000_0000_0000, 1'b1, '{64'd0, 1'b0}}
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_conversion predict_conversion(t_req_type kind,
                                                       logic [WordW-1:0] opnd);
        t_conversion      r;
        logic [WordW-1:0] divisor;
        logic [ExpW-1:0]  expo;
        r       = '0;
        divisor = '0;
        expo    = opnd[MantW+ExpW-1:MantW];
        case (kind)
            REQ_TGT_TO_DIFF: begin
                r.value = (opnd == '0) ? 64'd1 : AllOnes / opnd;
            end
            REQ_DIFF_TO_TGT: begin
                r.value = AllOnes / ((opnd == '0) ? 64'd1 : opnd);
            end
            REQ_CMPCT_TO_TGT: begin
                if (expo < ExpMin || expo > ExpMax) begin
                    r.bad = 1'b1;
                end else begin
                    // The shift drops whatever leaves the 64-bit word.
                    divisor = {{(WordW-MantW){1'b0}}, opnd[MantW-1:0]}
                              << (8 * (expo - ExpMin));
                    r.value = AllOnes / ((divisor == '0) ? 64'd1 : divisor);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [WordW-1:0] random_operand(t_req_type kind);
        logic [WordW-1:0] w;
        int unsigned      pick;
        w    = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (kind == REQ_CMPCT_TO_TGT) begin
            if (pick < 8)
                w[MantW+ExpW-1:MantW] = ExpW'($urandom_range(ExpMin, ExpMax));
            if (pick == 0)
                w[MantW-1:0] = '0;
            else if (pick == 1)
                w[MantW-1:0] = 24'h1 << $urandom_range(0, MantW - 1);
        end else begin
            case (pick)
                0: w = '0;
                1: w = 64'd1 << $urandom_range(0, WordW - 1);
                2: w = w >> $urandom_range(1, WordW - 1);
                3: w = AllOnes - WordW'($urandom_range(0, 3));
                4: w = WordW'($urandom_range(1, 300));
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [WordW-1:0] got,
                                   logic [WordW-1:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // Offers one request and records its expected response once the
    // transaction completes.
    task automatic send_request(t_req_type kind, logic [WordW-1:0] opnd,
                                t_conversion want);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.operand  <= opnd;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        pending_results.push_back(want);
    endtask

    initial begin : rsp_sink
        int          stall;
        t_conversion want;
        wait (i_rst_n === 1'b1);
        forever begin
            // Twice in the run the sink holds off long enough for the
            // request side to back up.
            if (rsp_count == 40 || rsp_count == 700)
                stall = LongHoldOff;
            else
                stall = burst_mode ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", rsp_if.result_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.result_value !== want.value)
                    report_mismatch("result_value", rsp_if.result_value, want.value);
                if (rsp_if.bad_exponent !== want.bad)
                    report_mismatch("bad_exponent", {63'd0, rsp_if.bad_exponent},
                                    {63'd0, want.bad});
            end
            rsp_count++;
        end
    end

    initial begin : stimulus
        t_req_type        kind;
        logic [WordW-1:0] opnd;
        t_conversion      want;
        int unsigned      pick;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        burst_mode      = 1'b0;
        mismatches      = 0;
        rsp_count       = 0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_TGT_TO_DIFF;
        req_if.operand  = '0;
        rsp_if.ready    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_vectors[i]) begin
            kind = directed_vectors[i].kind;
            opnd = directed_vectors[i].operand;
            want = directed_vectors[i].typed ? directed_vectors[i].want
                                             : predict_conversion(kind, opnd);
            send_request(kind, opnd, want);
        end

        for (int n = 0; n < NumRandom; n++) begin
            // Every fourth block of a hundred runs with no idling at all.
            burst_mode = ((n / 100) % 4 == 3);
            pick = $urandom_range(0, 19);
            if (pick < 6)
                kind = REQ_TGT_TO_DIFF;
            else if (pick < 12)
                kind = REQ_DIFF_TO_TGT;
            else if (pick < 19)
                kind = REQ_CMPCT_TO_TGT;
            else
                kind = REQ_UNUSED;
            opnd = random_operand(kind);
            send_request(kind, opnd, predict_conversion(kind, opnd));
        end
        req_if.valid <= 1'b0;
        burst_mode = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #1_500_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== difficulty_target_converter.f =====
rtl/dtc_pkg.sv
rtl/dtc_if.sv
rtl/dtc_div.sv
rtl/difficulty_target_converter.sv
verif/tb_difficulty_target_converter.sv
